FILE: hdl/euclidean_lsh_bucket_hash_top_defines.svh
// Assertion macros of the hash key generator, used by its datapath.
// Depends on nothing; included by the files that carry assertions.
`ifndef EUCLIDEAN_LSH_BUCKET_HASH_TOP_DEFINES_SVH
`define EUCLIDEAN_LSH_BUCKET_HASH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ELSH_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ELSH_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

FILE: hdl/elsh_pkg.sv
// Package of the hash key generator: sizes, codes and controller structs.
// Depends on nothing.
package elsh_pkg;

  localparam int MaxTables = 4;
  localparam int MaxProj   = 4;
  localparam int MaxDims   = 128;
  localparam int Slots     = MaxTables * MaxProj;

  localparam int TblW   = (MaxTables > 1) ? $clog2(MaxTables) : 1;
  localparam int PrjW   = (MaxProj > 1) ? $clog2(MaxProj) : 1;
  localparam int SlotW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int DimW   = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int CoefAW = ((Slots * MaxDims) > 1) ? $clog2(Slots * MaxDims) : 1;
  localparam int CntTW  = $clog2(MaxTables + 1);
  localparam int CntPW  = $clog2(MaxProj + 1);

  localparam logic [31:0] LshMod = 32'd4294967291;

  localparam int DivNW    = 49;
  localparam int DivDW    = 40;
  localparam int DivCntW  = $clog2(DivNW + 1);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 40;

  typedef enum logic [1:0] {
    OpElement    = 2'd0,
    OpLoadCoef   = 2'd1,
    OpLoadOffset = 2'd2,
    OpLoadWeight = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTables  = 3'd0,
    CfgProj    = 3'd1,
    CfgDims    = 3'd2,
    CfgWidth   = 3'd3,
    CfgDataset = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            mac_issue;
    logic            fin_div;
    logic            hmod;
    logic            mul;
    logic            fold;
    logic            fold2;
    logic            acc;
    logic            bkt_div;
    logic            sum_clr;
    logic            emit;
    logic            last_tbl;
    logic            acc_clr;
    logic [TblW-1:0] t;
    logic [PrjW-1:0] p;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             mac_busy;
    logic             div_busy;
    logic             out_free;
    logic             elem_last;
    logic [CntTW-1:0] nt;
    logic [CntPW-1:0] np;
  } ctrl_sts_t;

endpackage

FILE: hdl/elsh_if.sv
// Stream interfaces of the hash key generator: input words and result words.
// Depends on nothing.
interface elsh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  table_sel;
  logic [3:0]  proj_sel;
  logic [9:0]  dim_sel;
  logic [47:0] value;
  logic [23:0] item_index;

  modport source (output valid, operation, table_sel, proj_sel, dim_sel, value,
                  item_index, input ready);
  modport sink (input valid, operation, table_sel, proj_sel, dim_sel, value,
                item_index, output ready);
endinterface

interface elsh_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  table_id;
  logic [21:0] bucket;
  logic [31:0] locality_id;
  logic [23:0] point_id;
  logic        last_of_point;

  modport source (output valid, table_id, bucket, locality_id, point_id,
                  last_of_point, input ready);
  modport sink (input valid, table_id, bucket, locality_id, point_id,
                last_of_point, output ready);
endinterface

FILE: hdl/euclidean_lsh_bucket_hash_top.sv
// Top level of the Euclidean LSH bucket hash key generator.
// Depends on elsh_pkg, elsh_if, elsh_ctrl and elsh_dp.
//
//   Channel   Direction  Handshake        Word
//   in_i      in         valid/ready      operation, selects, value, item_index
//   out_o     out        valid/ready      table_id, bucket, locality_id, point_id, last
//   cfg       in         cfg_we_i only    register index and write data
//
// A load word is taken without leaving the idle state. A point element issues one
// multiply-accumulate on the one shared unit for each of the T*P pairs in use.
// After the last element each projection and each table pass through the shared
// divider, which yields one quotient bit per cycle.
// Reset clears control state and the dot accumulators at once; no clearing pass.
// Input is taken only while the controller is idle; a stalled result waits in the
// output register while the next input word can already be taken.
module euclidean_lsh_bucket_hash_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  elsh_in_if.sink                       in_i,
  elsh_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [elsh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [elsh_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import elsh_pkg::*;

  // The controller and the datapath talk through these two structs and the input ready.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  assign in_i.ready = in_ready;

  elsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the stores, the accumulators and the result register.
  elsh_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_i      (in_ready),
    .operation_i     (in_i.operation),
    .table_sel_i     (in_i.table_sel),
    .proj_sel_i      (in_i.proj_sel),
    .dim_sel_i       (in_i.dim_sel),
    .value_i         (in_i.value),
    .item_index_i    (in_i.item_index),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .table_id_o      (out_o.table_id),
    .bucket_o        (out_o.bucket),
    .locality_id_o   (out_o.locality_id),
    .point_id_o      (out_o.point_id),
    .last_of_point_o (out_o.last_of_point)
  );

endmodule

FILE: hdl/elsh_div.sv
// Restoring divider, one quotient bit per cycle, shared by quantizing and bucketing.
// Depends on elsh_pkg.
module elsh_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [elsh_pkg::DivNW-1:0] dividend_i,
  input  logic [elsh_pkg::DivDW-1:0] divisor_i,
  output logic                       busy_o,
  output logic [elsh_pkg::DivNW-1:0] quot_o,
  output logic [elsh_pkg::DivDW-1:0] rem_o
);
  import elsh_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNW-1:0]   quo_q, quo_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivDW-1:0]   dsr_q, dsr_d;
  logic [DivDW:0]     trial;
  logic               fits;

  always_comb begin
    trial  = {rem_q, quo_q[DivNW-1]};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DivNW-2:0], fits};
      rem_d = fits ? DivDW'(trial - {1'b0, dsr_q}) : DivDW'(trial);
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/elsh_dp.sv
// Datapath: stores, dot-product pipeline, modular reduction and result register.
// Depends on elsh_pkg, elsh_div and the assertion macro header.
`include "euclidean_lsh_bucket_hash_top_defines.svh"

module elsh_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   operation_i,
  input  logic [3:0]                   table_sel_i,
  input  logic [3:0]                   proj_sel_i,
  input  logic [9:0]                   dim_sel_i,
  input  logic [47:0]                  value_i,
  input  logic [23:0]                  item_index_i,
  input  logic                         cfg_we_i,
  input  logic [elsh_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [elsh_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  elsh_pkg::ctrl_cmd_t          cmd_i,
  output elsh_pkg::ctrl_sts_t          sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   table_id_o,
  output logic [21:0]                  bucket_o,
  output logic [31:0]                  locality_id_o,
  output logic [23:0]                  point_id_o,
  output logic                         last_of_point_o
);
  import elsh_pkg::*;

  // Configuration registers.
  logic [4:0]  tables_q, proj_q;
  logic [10:0] dims_q;
  logic [39:0] width_q;
  logic [23:0] dataset_q;

  logic [CntTW-1:0] nt;
  logic [CntPW-1:0] np;
  logic [10:0]      nd;
  logic [39:0]      w_eff;
  logic [21:0]      nb_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tables_q  <= 5'd4;
      proj_q    <= 5'd4;
      dims_q    <= 11'd128;
      width_q   <= 40'd4194304;
      dataset_q <= 24'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTables:  tables_q  <= cfg_wdata_i[4:0];
        CfgProj:    proj_q    <= cfg_wdata_i[4:0];
        CfgDims:    dims_q    <= cfg_wdata_i[10:0];
        CfgWidth:   width_q   <= cfg_wdata_i[39:0];
        CfgDataset: dataset_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tables_q == 5'd0) nt = CntTW'(1);
    else if (tables_q > 5'(MaxTables)) nt = CntTW'(MaxTables);
    else nt = CntTW'(tables_q);
    if (proj_q == 5'd0) np = CntPW'(1);
    else if (proj_q > 5'(MaxProj)) np = CntPW'(MaxProj);
    else np = CntPW'(proj_q);
    if (dims_q == 11'd0) nd = 11'd1;
    else if (dims_q > 11'(MaxDims)) nd = 11'(MaxDims);
    else nd = dims_q;
    w_eff  = (width_q == 40'd0) ? 40'd1 : width_q;
    nb_eff = (dataset_q[23:2] == 22'd0) ? 22'd1 : dataset_q[23:2];
  end

  // Input decode and stores.
  logic              in_fire, elem_fire, addr_ok;
  logic [SlotW-1:0]  ld_slot;
  logic [CoefAW-1:0] ld_addr;
  logic [10:0]       cnt_q;
  logic [10:0]       cnt_inc;
  logic              elem_last;

  assign in_fire   = in_valid_i && in_ready_i;
  assign elem_fire = in_fire && (op_e'(operation_i) == OpElement);
  assign addr_ok   = (5'(table_sel_i) < 5'(MaxTables)) && (5'(proj_sel_i) < 5'(MaxProj));
  assign ld_slot   = SlotW'(int'(table_sel_i) * MaxProj + int'(proj_sel_i));
  assign ld_addr   = CoefAW'(int'(ld_slot) * MaxDims + int'(dim_sel_i));
  assign cnt_inc   = cnt_q + 11'd1;
  assign elem_last = cnt_inc >= nd;

  logic [15:0] coef_mem [Slots*MaxDims];
  logic [47:0] off_q    [Slots];
  logic [29:0] wgt_q    [Slots];

  always_ff @(posedge clk_i) begin
    if (in_fire && addr_ok && (op_e'(operation_i) == OpLoadCoef) &&
        (11'(dim_sel_i) < 11'(MaxDims))) begin
      coef_mem[ld_addr] <= value_i[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && addr_ok && (op_e'(operation_i) == OpLoadOffset)) begin
      off_q[ld_slot] <= value_i;
    end
    if (in_fire && addr_ok && (op_e'(operation_i) == OpLoadWeight)) begin
      wgt_q[ld_slot] <= value_i[29:0];
    end
  end

  // Element latch and element counter.
  logic signed [15:0] x_q;
  logic [23:0]        item_q;
  logic [DimW-1:0]    d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (elem_fire) begin
      cnt_q <= elem_last ? 11'd0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_fire) begin
      x_q    <= value_i[15:0];
      item_q <= item_index_i;
      d_q    <= DimW'(cnt_q % MaxDims);
    end
  end

  // Multiply-accumulate pipeline: coefficient read, multiply, accumulate.
  logic [SlotW-1:0]   cur_slot;
  logic [15:0]        coef_rd_q;
  logic signed [31:0] prod_q;
  logic               v1_q, v2_q;
  logic [SlotW-1:0]   s1_q, s2_q;
  logic [47:0]        acc_q [Slots];

  assign cur_slot = SlotW'(int'(cmd_i.t) * MaxProj + int'(cmd_i.p));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_issue) begin
      coef_rd_q <= coef_mem[CoefAW'(int'(cur_slot) * MaxDims + int'(d_q))];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(coef_rd_q) * x_q;
    s1_q   <= cur_slot;
    s2_q   <= s1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int i = 0; i < Slots; i++) acc_q[i] <= '0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
      if (cmd_i.acc_clr) begin
        for (int i = 0; i < Slots; i++) acc_q[i] <= '0;
      end else if (v2_q) begin
        acc_q[s2_q] <= acc_q[s2_q] + {{16{prod_q[31]}}, prod_q};
      end
    end
  end

  // Quantization and modular reduction.
  logic [48:0]      num, mag;
  logic             div_start, div_busy;
  logic [DivNW-1:0] div_n, quot;
  logic [DivDW-1:0] div_d, rem;
  logic             neg_q;
  logic [31:0]      sum_q;

  assign num = {acc_q[cur_slot][47], acc_q[cur_slot]} +
               {off_q[cur_slot][47], off_q[cur_slot]};
  assign mag = num[48] ? (~num + 49'd1) : num;

  assign div_start = cmd_i.fin_div || cmd_i.bkt_div;
  assign div_n     = cmd_i.bkt_div ? DivNW'(sum_q) : mag;
  assign div_d     = cmd_i.bkt_div ? DivDW'(nb_eff) : w_eff;

  elsh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  logic [49:0] hv;
  logic [34:0] r1;
  logic [31:0] hm;
  logic [31:0] hn_q;
  logic [61:0] wp_q;
  logic [33:0] f1_q;
  logic [32:0] f2, sacc;
  logic [31:0] term_q;

  // The magnitude of a negative floor quotient is the truncated quotient plus
  // one when the division leaves a remainder. 2^32 is congruent to 5 modulo M.
  always_comb begin
    hv   = neg_q ? (50'(quot) + 50'(rem != '0)) : 50'(quot);
    r1   = 35'(hv[49:32]) * 35'd5 + 35'(hv[31:0]);
    hm   = (r1 >= 35'(LshMod)) ? 32'(r1 - 35'(LshMod)) : 32'(r1);
    f2   = 33'(f1_q[33:32]) * 33'd5 + 33'(f1_q[31:0]);
    sacc = 33'(sum_q) + 33'(term_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_div) neg_q <= num[48];
    if (cmd_i.hmod) hn_q <= (neg_q && (hm != 32'd0)) ? (LshMod - hm) : hm;
    if (cmd_i.mul) wp_q <= 62'(wgt_q[cur_slot]) * 62'(hn_q);
    if (cmd_i.fold) f1_q <= 34'(wp_q[61:32]) * 34'd5 + 34'(wp_q[31:0]);
    if (cmd_i.fold2) term_q <= (f2 >= 33'(LshMod)) ? 32'(f2 - 33'(LshMod)) : 32'(f2);
    if (cmd_i.sum_clr) sum_q <= 32'd0;
    else if (cmd_i.acc) sum_q <= (sacc >= 33'(LshMod)) ? 32'(sacc - 33'(LshMod)) : 32'(sacc);
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      table_id_o      <= 4'(cmd_i.t);
      bucket_o        <= rem[21:0];
      locality_id_o   <= sum_q;
      point_id_o      <= item_q;
      last_of_point_o <= cmd_i.last_tbl;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.mac_busy  = v1_q || v2_q;
    sts_o.div_busy  = div_busy;
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.elem_last = elem_last;
    sts_o.nt        = nt;
    sts_o.np        = np;
  end

  `ELSH_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd_i.emit, (!out_valid_q || out_ready_i))
  `ELSH_ASSERT_IMP(a_div_idle, clk_i, rst_ni, div_start, !div_busy)
  `ELSH_ASSERT_IMP(a_elem_drained, clk_i, rst_ni, elem_fire, (!v1_q && !v2_q))
  `ELSH_ASSERT_NXT(a_emit_shows, clk_i, rst_ni, cmd_i.emit, out_valid_q)

endmodule

FILE: hdl/elsh_ctrl.sv
// Controller state machine: sequences accumulation, quantization and result emission.
// Depends on elsh_pkg.
module elsh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          operation_i,
  output logic                in_ready_o,
  input  elsh_pkg::ctrl_sts_t sts_i,
  output elsh_pkg::ctrl_cmd_t cmd_o
);
  import elsh_pkg::*;

  typedef enum logic [12:0] {
    StIdle     = 13'b0000000000001,
    StMac      = 13'b0000000000010,
    StDrain    = 13'b0000000000100,
    StDiv      = 13'b0000000001000,
    StDivWait  = 13'b0000000010000,
    StHmod     = 13'b0000000100000,
    StMul      = 13'b0000001000000,
    StFold     = 13'b0000010000000,
    StFold2    = 13'b0000100000000,
    StAcc      = 13'b0001000000000,
    StBdiv     = 13'b0010000000000,
    StBdivWait = 13'b0100000000000,
    StEmit     = 13'b1000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [TblW-1:0] t_q, t_d;
  logic [PrjW-1:0] p_q, p_d;
  logic            last_q, last_d;
  logic            t_end, p_end;

  assign t_end = (CntTW'(t_q) + CntTW'(1)) == sts_i.nt;
  assign p_end = (CntPW'(p_q) + CntPW'(1)) == sts_i.np;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    p_d     = p_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.t = t_q;
    cmd_o.p = p_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && (op_e'(operation_i) == OpElement)) begin
          t_d     = '0;
          p_d     = '0;
          last_d  = sts_i.elem_last;
          state_d = StMac;
        end
      end
      StMac: begin
        cmd_o.mac_issue = 1'b1;
        if (p_end) begin
          p_d = '0;
          if (t_end) state_d = StDrain;
          else t_d = t_q + TblW'(1);
        end else begin
          p_d = p_q + PrjW'(1);
        end
      end
      StDrain: begin
        if (!sts_i.mac_busy) begin
          if (last_q) begin
            t_d           = '0;
            p_d           = '0;
            cmd_o.sum_clr = 1'b1;
            state_d       = StDiv;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StDiv: begin
        cmd_o.fin_div = 1'b1;
        state_d       = StDivWait;
      end
      StDivWait: begin
        if (!sts_i.div_busy) state_d = StHmod;
      end
      StHmod: begin
        cmd_o.hmod = 1'b1;
        state_d    = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        state_d    = StFold2;
      end
      StFold2: begin
        cmd_o.fold2 = 1'b1;
        state_d     = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        if (p_end) begin
          state_d = StBdiv;
        end else begin
          p_d     = p_q + PrjW'(1);
          state_d = StDiv;
        end
      end
      StBdiv: begin
        cmd_o.bkt_div = 1'b1;
        state_d       = StBdivWait;
      end
      StBdivWait: begin
        if (!sts_i.div_busy) state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.last_tbl = t_end;
          p_d            = '0;
          if (t_end) begin
            cmd_o.acc_clr = 1'b1;
            state_d       = StIdle;
          end else begin
            t_d           = t_q + TblW'(1);
            cmd_o.sum_clr = 1'b1;
            state_d       = StDiv;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      t_q     <= '0;
      p_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      p_q     <= p_d;
      last_q  <= last_d;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the Euclidean LSH bucket hash key generator.
// Depends on elsh_pkg, the elsh_in_if and elsh_out_if interfaces and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import elsh_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  // Idle time before a register write: covers the longest finishing pass.
  localparam int unsigned SettleCycles = 1500;
  localparam int unsigned HoldCycles = 3000;
  // Coefficients loaded per projection; points never index past them.
  localparam int unsigned FillDims = 8;
  localparam longint unsigned ModU = 64'd4294967291;
  localparam longint ModS = 64'sd4294967291;

  // One input word and one predicted key.
  typedef struct {
    op_e         op;
    logic [3:0]  tsel;
    logic [3:0]  psel;
    logic [9:0]  dsel;
    logic [47:0] val;
    logic [23:0] idx;
  } hash_word_t;

  typedef struct {
    logic [3:0]  table_id;
    logic [21:0] bucket;
    logic [31:0] locality_id;
    logic [23:0] point_id;
    logic        last_of_point;
  } hash_key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CfgTables;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  elsh_in_if in_if ();
  elsh_out_if out_if ();

  euclidean_lsh_bucket_hash_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // The testbench keeps its own copy of the stores, dot sums, element counter and registers.
  logic [15:0] coef_mem [Slots*MaxDims];
  logic [47:0] offset_mem [Slots];
  logic [29:0] weight_mem [Slots];
  logic [47:0] dot_sum [Slots];
  logic [10:0] elem_cnt;
  logic [4:0]  reg_tables;
  logic [4:0]  reg_proj;
  logic [10:0] reg_dims;
  logic [39:0] reg_width;
  logic [23:0] reg_dataset;

  hash_key_t pending_keys[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req = 0;

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = OpElement;
    in_if.table_sel = '0;
    in_if.proj_sel = '0;
    in_if.dim_sel = '0;
    in_if.value = '0;
    in_if.item_index = '0;
    out_if.ready = 1'b0;
  end

  // A cycle counter guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("euclidean_lsh_bucket_hash_top regression: fail");
      $finish;
    end
  end

  // The receiver draws its stall pattern anew at set points of its phase counter. A hold-off request
  // from a test task holds ready low for a long stretch counted here.
  int unsigned rx_mode = 0;
  int unsigned rx_phase = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 256 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= (rx_phase % 7 < 2);
        default: out_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Every accepted result word is compared with the oldest predicted key.
  always @(posedge clk) begin
    hash_key_t exp_key;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_keys.size() == 0) begin
        $error("unexpected result word: table_id %0d locality_id %0d",
               out_if.table_id, out_if.locality_id);
        errors++;
      end else begin
        exp_key = pending_keys.pop_front();
        if (out_if.table_id !== exp_key.table_id) begin
          $error("table_id: expected %0d, actual %0d", exp_key.table_id, out_if.table_id);
          errors++;
        end
        if (out_if.bucket !== exp_key.bucket) begin
          $error("bucket: expected %0d, actual %0d", exp_key.bucket, out_if.bucket);
          errors++;
        end
        if (out_if.locality_id !== exp_key.locality_id) begin
          $error("locality_id: expected %0d, actual %0d", exp_key.locality_id,
                 out_if.locality_id);
          errors++;
        end
        if (out_if.point_id !== exp_key.point_id) begin
          $error("point_id: expected %0d, actual %0d", exp_key.point_id, out_if.point_id);
          errors++;
        end
        if (out_if.last_of_point !== exp_key.last_of_point) begin
          $error("last_of_point: expected %0d, actual %0d", exp_key.last_of_point,
                 out_if.last_of_point);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Quantizes every projection of the finished point and combines them into one key per table.
  function automatic void hash_point(logic [23:0] point);
    int unsigned nt;
    int unsigned np;
    int unsigned s;
    longint wdiv;
    longint num;
    longint quot;
    longint hm;
    longint unsigned nb;
    longint unsigned sum;
    hash_key_t key;
    nt = clamp_count(reg_tables, MaxTables);
    np = clamp_count(reg_proj, MaxProj);
    wdiv = (reg_width == 0) ? 64'sd1 : longint'({24'd0, reg_width});
    nb = reg_dataset / 4;
    if (nb == 0) nb = 1;
    for (int unsigned t = 0; t < nt; t++) begin
      sum = 0;
      for (int unsigned p = 0; p < np; p++) begin
        s = t * MaxProj + p;
        num = longint'($signed(dot_sum[s])) + longint'($signed(offset_mem[s]));
        quot = num / wdiv;
        if ((num % wdiv) != 0 && num < 0) quot = quot - 1;
        hm = quot % ModS;
        if (hm < 0) hm = hm + ModS;
        sum = (sum + (longint'(weight_mem[s]) * longint'(hm)) % ModU) % ModU;
      end
      key.table_id = t[3:0];
      key.bucket = 22'(sum % nb);
      key.locality_id = sum[31:0];
      key.point_id = point;
      key.last_of_point = (t + 1 == nt);
      pending_keys = {pending_keys, key};
    end
    for (int unsigned i = 0; i < Slots; i++) dot_sum[i] = '0;
    elem_cnt = '0;
  endfunction

  // Updates the copied state for one accepted word.
  function automatic void predict_word(hash_word_t w);
    int unsigned nt;
    int unsigned np;
    int unsigned s;
    longint prod;
    if (w.op != OpElement) begin
      if (w.tsel >= MaxTables || w.psel >= MaxProj) return;
      s = w.tsel * MaxProj + w.psel;
      case (w.op)
        OpLoadCoef: if (w.dsel < MaxDims) coef_mem[s * MaxDims + w.dsel] = w.val[15:0];
        OpLoadOffset: offset_mem[s] = w.val;
        default: weight_mem[s] = w.val[29:0];
      endcase
      return;
    end
    nt = clamp_count(reg_tables, MaxTables);
    np = clamp_count(reg_proj, MaxProj);
    for (int unsigned t = 0; t < nt; t++) begin
      for (int unsigned p = 0; p < np; p++) begin
        s = t * MaxProj + p;
        prod = longint'($signed(coef_mem[s * MaxDims + (elem_cnt % MaxDims)])) *
               longint'($signed(w.val[15:0]));
        dot_sum[s] = dot_sum[s] + prod[47:0];
      end
    end
    elem_cnt = elem_cnt + 11'd1;
    if (elem_cnt >= clamp_count(reg_dims, MaxDims)) hash_point(w.idx);
  endfunction

  // Offers one word, waits for it to be taken, and sometimes opens a gap.
  // Valid is left high when the burst goes on, so the next call follows at once.
  task automatic send_word(hash_word_t w);
    in_if.valid <= 1'b1;
    in_if.operation <= w.op;
    in_if.table_sel <= w.tsel;
    in_if.proj_sel <= w.psel;
    in_if.dim_sel <= w.dsel;
    in_if.value <= w.val;
    in_if.item_index <= w.idx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_word(w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Registers change only once the block has gone idle.
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    in_if.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgTables: reg_tables = data[4:0];
      CfgProj: reg_proj = data[4:0];
      CfgDims: reg_dims = data[10:0];
      CfgWidth: reg_width = data[39:0];
      default: reg_dataset = data[23:0];
    endcase
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic hash_word_t make_word(op_e op, int unsigned ts, int unsigned ps,
                                           int unsigned ds, logic [47:0] val);
    hash_word_t w;
    w.op = op;
    w.tsel = ts[3:0];
    w.psel = ps[3:0];
    w.dsel = ds[9:0];
    w.val = val;
    w.idx = 24'($urandom());
    return w;
  endfunction

  function automatic hash_word_t element(logic [47:0] val);
    return make_word(OpElement, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 1023), val);
  endfunction

  // Load every offset and weight and the leading coefficients of every projection.
  // Points stay short enough that no element reads a coefficient beyond them.
  task automatic test_store_fill();
    logic [15:0] c;
    for (int unsigned s = 0; s < Slots; s++) begin
      for (int unsigned d = 0; d < FillDims; d++) begin
        case ($urandom_range(0, 9))
          0: c = 16'h8000;
          1: c = 16'h7FFF;
          default: c = 16'($urandom());
        endcase
        send_word(make_word(OpLoadCoef, s / MaxProj, s % MaxProj, d,
                            48'({rand48() >> 16, c})));
      end
      send_word(make_word(OpLoadOffset, s / MaxProj, s % MaxProj, 0, rand48() >>> 16));
      send_word(make_word(OpLoadWeight, s / MaxProj, s % MaxProj, 0,
                          s == 0 ? 48'h3FFF_FFFF : rand48()));
    end
  endtask

  // Field extremes, every operation and the special cases of the block.
  task automatic test_directed();
    write_reg(CfgDims, 2);
    send_word(element(48'h0000_0000_8000));
    send_word(make_word(OpLoadOffset, 1, 2, 0, 48'h7FFF_FFFF_FFFF));
    send_word(element(48'hFFFF_FFFF_7FFF));
    send_word(make_word(OpLoadWeight, 3, 3, 0, 48'hFFFF_FFFF_FFFF));
    send_word(make_word(OpLoadOffset, 0, 0, 0, 48'h8000_0000_0000));
    // Loads beyond the store sizes are dropped without any effect.
    send_word(make_word(OpLoadCoef, 15, 0, 0, rand48()));
    send_word(make_word(OpLoadCoef, 0, 15, 0, rand48()));
    send_word(make_word(OpLoadCoef, 0, 0, 1023, rand48()));
    send_word(make_word(OpLoadWeight, 4, 0, 0, rand48()));
    send_word(element(48'h0));
    send_word(element(48'hFFFF_FFFF_FFFF));
    // Counts below and above their range saturate, a zero width acts as one.
    write_reg(CfgTables, 0);
    write_reg(CfgProj, 31);
    write_reg(CfgDims, 0);
    write_reg(CfgWidth, 0);
    write_reg(CfgDataset, 3);
    send_word(element(48'h7FFF));
    write_reg(CfgTables, 31);
    write_reg(CfgProj, 0);
    write_reg(CfgWidth, 40'hFF_FFFF_FFFF);
    write_reg(CfgDataset, 24'hFF_FFFF);
    send_word(element(48'h8000));
    write_reg(CfgDataset, 0);
    write_reg(CfgWidth, 1);
    send_word(element(48'h1234));
    // The point length changes while a point is half done.
    write_reg(CfgProj, 4);
    write_reg(CfgDataset, 4);
    write_reg(CfgDims, 2047);
    repeat (3) send_word(element(rand48()));
    write_reg(CfgDims, 1);
    send_word(element(rand48()));
  endtask

  // Phases of random settings, each followed by a stream of mostly elements.
  task automatic test_random_phases();
    int unsigned k;
    for (int unsigned ph = 0; ph < 8; ph++) begin
      write_reg(CfgTables, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 4));
      write_reg(CfgProj, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                  : $urandom_range(1, 4));
      write_reg(CfgDims, $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 6));
      case ($urandom_range(0, 5))
        0: write_reg(CfgWidth, 40'($urandom_range(0, 3)));
        1: write_reg(CfgWidth, {$urandom(), 8'($urandom())});
        default: write_reg(CfgWidth, 40'(1) << $urandom_range(10, 36));
      endcase
      write_reg(CfgDataset, 24'($urandom()) >> $urandom_range(0, 23));
      for (int unsigned i = 0; i < 27; i++) begin
        k = $urandom_range(0, 19);
        if (k < 17) begin
          send_word(element(rand48()));
        end else begin
          send_word(make_word(op_e'($urandom_range(1, 3)),
                              $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 15),
                              $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 15),
                              $urandom_range(0, 1) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 1023),
                              rand48()));
        end
      end
    end
  endtask

  // One-element points fill the result path while the receiver holds off.
  task automatic test_backpressure();
    write_reg(CfgTables, 4);
    write_reg(CfgProj, 1);
    write_reg(CfgDims, 1);
    write_reg(CfgWidth, 40'h1_0000);
    write_reg(CfgDataset, 24'h00_1000);
    hold_req = hold_req + 1;
    burst_left = 30;
    for (int unsigned i = 0; i < 20; i++) send_word(element(rand48()));
  endtask

  initial begin
    for (int unsigned i = 0; i < Slots; i++) dot_sum[i] = '0;
    elem_cnt = '0;
    reg_tables = 5'd4;
    reg_proj = 5'd4;
    reg_dims = 11'd128;
    reg_width = 40'd4194304;
    reg_dataset = 24'd1024;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_store_fill();
    test_directed();
    test_random_phases();
    test_backpressure();
    in_if.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("euclidean_lsh_bucket_hash_top regression: pass");
    end else begin
      $display("euclidean_lsh_bucket_hash_top regression: fail");
    end
    $finish;
  end
endmodule
